// File: sv/fpvt_pkg.sv
//------------------------------------------------------------------------------
// fpvt_pkg
// shared types and constants for the fixed-point 3x3 vector transform
//------------------------------------------------------------------------------
`default_nettype none

package fpvt_pkg;

    // field widths
    localparam int COEF_W  = 16;
    localparam int COMP_W  = 32;
    localparam int ROW_W   = 3 * COEF_W;
    localparam int PROD_W  = COEF_W + COMP_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = ROW_W;
    localparam int NUM_LANES  = 3;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [COMP_W-1:0] comp_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    // register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_X = 3'd0,
        REG_ROW_Y = 3'd1,
        REG_ROW_Z = 3'd2,
        REG_OFF_X = 3'd3,
        REG_OFF_Y = 3'd4,
        REG_OFF_Z = 3'd5
    } cfg_reg_t;

    // coefficients indexed [row][lane], row = source component, lane = result
    typedef struct packed {
        logic [NUM_LANES-1:0][NUM_LANES-1:0][COEF_W-1:0] coef;
        logic [NUM_LANES-1:0][COMP_W-1:0]                offset;
    } fpvt_cfg_t;

endpackage

`default_nettype wire

// File: sv/fpvt_cfg.sv
//------------------------------------------------------------------------------
// fpvt_cfg
// configuration register file: matrix rows and translation
//------------------------------------------------------------------------------
`default_nettype none

module fpvt_cfg #(
    parameter int FRAC_BITS = 12
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire  [fpvt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [fpvt_pkg::CFG_DATA_W-1:0]      cfg_data,
    output fpvt_pkg::fpvt_cfg_t                  cfg_o
);
    import fpvt_pkg::*;

    localparam logic [COEF_W-1:0] ONE = COEF_W'(1 << FRAC_BITS);

    logic [NUM_LANES-1:0][ROW_W-1:0]  row_reg;
    logic [NUM_LANES-1:0][COMP_W-1:0] off_reg;
    logic [NUM_LANES-1:0][ROW_W-1:0]  row_next;
    logic [NUM_LANES-1:0][COMP_W-1:0] off_next;

    // writes are always taken
    assign cfg_ready = 1'b1;

    // register write decode, unknown indexes are dropped
    always_comb begin
        row_next = row_reg;
        off_next = off_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_ROW_X: row_next[0] = cfg_data;
                REG_ROW_Y: row_next[1] = cfg_data;
                REG_ROW_Z: row_next[2] = cfg_data;
                REG_OFF_X: off_next[0] = cfg_data[COMP_W-1:0];
                REG_OFF_Y: off_next[1] = cfg_data[COMP_W-1:0];
                REG_OFF_Z: off_next[2] = cfg_data[COMP_W-1:0];
                default: ;
            endcase
        end
    end

    // identity matrix and zero translation after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg[0] <= {{(2*COEF_W){1'b0}}, ONE};
            row_reg[1] <= {{COEF_W{1'b0}}, ONE, {COEF_W{1'b0}}};
            row_reg[2] <= {ONE, {(2*COEF_W){1'b0}}};
            off_reg    <= '0;
        end else begin
            row_reg <= row_next;
            off_reg <= off_next;
        end
    end

    // unpack rows into per-coefficient view
    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            for (int j = 0; j < NUM_LANES; j++) begin
                cfg_o.coef[i][j] = row_reg[i][j*COEF_W +: COEF_W];
            end
        end
        cfg_o.offset = off_reg;
    end

endmodule

`default_nettype wire

// File: sv/fixed_point_vector_transform.sv
//------------------------------------------------------------------------------
// fixed_point_vector_transform
// row vector times configured 3x3 fixed-point matrix, optional translation
//------------------------------------------------------------------------------
// throughput: one vector per cycle unless m_tready stalls it; four register stages
//   (multiply, truncate toward zero, three-term sum, offset add)
// reset: synchronous active-low aresetn empties the pipeline, loads the
//   identity matrix and a zero translation
//------------------------------------------------------------------------------
`default_nettype none

module fixed_point_vector_transform #(
    parameter int FRAC_BITS = 12
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    // input stream
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    input  wire  [3*fpvt_pkg::COMP_W-1:0]        s_tdata,  // in_x, in_y, in_z
    input  wire                                  s_tuser,  // add_offset
    // result stream
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    output logic [3*fpvt_pkg::COMP_W-1:0]        m_tdata,  // out_x, out_y, out_z
    // configuration writes
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire  [fpvt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [fpvt_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import fpvt_pkg::*;

    fpvt_cfg_t cfg;

    // per-stage advance enables
    logic adv1, adv2, adv3, adv4;
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic add1_reg, add2_reg, add3_reg;

    coef_t coef_s [NUM_LANES][NUM_LANES];
    comp_t in_s   [NUM_LANES];

    prod_t prod_next [NUM_LANES][NUM_LANES];
    prod_t prod_reg  [NUM_LANES][NUM_LANES];
    logic [COMP_W-1:0] quo_next [NUM_LANES][NUM_LANES];
    logic [COMP_W-1:0] quo_reg  [NUM_LANES][NUM_LANES];
    logic [COMP_W-1:0] sum_next [NUM_LANES];
    logic [COMP_W-1:0] sum_reg  [NUM_LANES];
    logic [COMP_W-1:0] out_next [NUM_LANES];
    logic [COMP_W-1:0] out_reg  [NUM_LANES];

    fpvt_cfg #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_o     (cfg)
    );

    // a stage moves when it is empty or the next one moves
    assign adv4     = !v4_reg || m_tready;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign s_tready = adv1;

    // signed views of coefficients and input components
    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            in_s[i] = s_tdata[i*COMP_W +: COMP_W];
            for (int j = 0; j < NUM_LANES; j++) begin
                coef_s[i][j] = cfg.coef[i][j];
            end
        end
    end

    // stage 1: nine 16x32 products
    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            for (int j = 0; j < NUM_LANES; j++) begin
                prod_next[i][j] = coef_s[i][j] * in_s[i];
            end
        end
    end

    // stage 2: divide by one toward zero, keep the low result bits
    always_comb begin
        logic [PROD_W-1:0] biased;
        biased = '0;
        for (int i = 0; i < NUM_LANES; i++) begin
            for (int j = 0; j < NUM_LANES; j++) begin
                biased = prod_reg[i][j]
                       + {{(PROD_W-FRAC_BITS){1'b0}}, {FRAC_BITS{prod_reg[i][j][PROD_W-1]}}};
                quo_next[i][j] = biased[FRAC_BITS +: COMP_W];
            end
        end
    end

    // stage 3: three-term sum per lane, wrapping
    always_comb begin
        for (int j = 0; j < NUM_LANES; j++) begin
            sum_next[j] = quo_reg[0][j] + quo_reg[1][j] + quo_reg[2][j];
        end
    end

    // stage 4: optional translation
    always_comb begin
        for (int j = 0; j < NUM_LANES; j++) begin
            out_next[j] = add3_reg ? sum_reg[j] + cfg.offset[j] : sum_reg[j];
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= s_tvalid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (adv1) begin
            prod_reg <= prod_next;
            add1_reg <= s_tuser;
        end
        if (adv2) begin
            quo_reg  <= quo_next;
            add2_reg <= add1_reg;
        end
        if (adv3) begin
            sum_reg  <= sum_next;
            add3_reg <= add2_reg;
        end
        if (adv4) begin
            out_reg  <= out_next;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {out_reg[2], out_reg[1], out_reg[0]};

    // a ready sink always lets the pipeline take a new word
    a_sink_ready_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output sink is ready");

    // backpressure reaches the input only when every stage is full
    a_stall_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (v1_reg && v2_reg && v3_reg && v4_reg))
        else $error("input stalled with a bubble in the pipeline");

    // an accepted word occupies the first stage next cycle
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> v1_reg)
        else $error("accepted word lost at stage one");

endmodule

`default_nettype wire

// File: test/fixed_point_vector_transform_test.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// fixed_point_vector_transform_test
// self-checking bench for the 3x3 fixed-point vector transform
//------------------------------------------------------------------------------
// A clocked driver feeds vectors from a queue onto the input stream. A
// clocked monitor predicts each accepted word from a local copy of the
// matrix and translation, then compares each result word field by field.
// Register writes happen only between phases, once the pipeline is empty.
// Both stream sides idle at random. One phase runs with no idling, and one
// phase holds the result side off long enough to back up the input.
//------------------------------------------------------------------------------

module fixed_point_vector_transform_test;

    import fpvt_pkg::*;

    localparam int FRAC_BITS = 12;
    localparam longint UNITY = longint'(1) << FRAC_BITS;
    localparam int CLK_HALF = 5;
    localparam int RESET_CYCLES = 8;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_VECTORS = 240;
    localparam int IDLE_PERCENT = 16;
    localparam int STEADY_PHASE = 3;
    localparam int PRESSURE_PHASE = 1;

    // indexes past the register list, writes there are dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    localparam comp_t COMP_MIN = 32'sh8000_0000;
    localparam comp_t COMP_MAX = 32'sh7fff_ffff;
    localparam coef_t COEF_MIN = 16'sh8000;
    localparam coef_t COEF_MAX = 16'sh7fff;

    // x sits in the lowest bits, as on the stream buses
    typedef struct packed {
        comp_t z;
        comp_t y;
        comp_t x;
    } vec3_t;

    typedef struct packed {
        logic  add_offset;
        vec3_t v;
    } src_word_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } reg_write_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [3*COMP_W-1:0]     s_tdata = '0;   // in_x, in_y, in_z
    logic                    s_tuser = 1'b0; // add_offset
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [3*COMP_W-1:0]     m_tdata;        // out_x, out_y, out_z
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    src_word_t  pending_vectors[$];
    reg_write_t pending_writes[$];
    vec3_t      predicted_outputs[$];

    // local copy of the matrix [source row][result lane] and translation
    coef_t matrix_coef[3][3];
    comp_t offset_lane[3];

    int  error_count = 0;
    bit  steady = 1'b0;
    bit  pressure_armed = 1'b0;
    bit  held_once = 1'b0;
    int  hold_left = 0;

    fixed_point_vector_transform #(
        .FRAC_BITS (FRAC_BITS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // identity matrix and zero translation, as after reset
    function automatic void load_reset_matrix();
        for (int r = 0; r < 3; r++) begin
            for (int l = 0; l < 3; l++) begin
                matrix_coef[r][l] = (r == l) ? coef_t'(UNITY) : coef_t'(0);
            end
            offset_lane[r] = '0;
        end
    endfunction

    // row vector times matrix, each product truncated toward zero
    function automatic vec3_t transform_vector(vec3_t src, logic add_offset);
        longint comp[3];
        longint acc;
        comp_t  lane_out[3];
        vec3_t  res;
        comp[0] = longint'(src.x);
        comp[1] = longint'(src.y);
        comp[2] = longint'(src.z);
        for (int l = 0; l < 3; l++) begin
            acc = 0;
            for (int r = 0; r < 3; r++) begin
                acc += (longint'(matrix_coef[r][l]) * comp[r]) / UNITY;
            end
            if (add_offset) begin
                acc += longint'(offset_lane[l]);
            end
            lane_out[l] = acc[COMP_W-1:0];
        end
        res.x = lane_out[0];
        res.y = lane_out[1];
        res.z = lane_out[2];
        return res;
    endfunction

    function automatic void check_lane(string name, comp_t want, comp_t got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endfunction

    // input driver
    always @(posedge aclk) begin : drive_input
        src_word_t w;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_vectors.size() != 0 &&
                (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
                w = pending_vectors.pop_front();
                s_tdata  <= w.v;
                s_tuser  <= w.add_offset;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side ready, with one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (pressure_armed && !held_once) begin
            held_once <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= steady || $urandom_range(99) >= IDLE_PERCENT;
        end
    end

    // register write driver
    always @(posedge aclk) begin : drive_config
        reg_write_t w;
        if (!aresetn) begin
            cfg_valid <= 1'b0;
        end else if (!cfg_valid || cfg_ready) begin
            if (pending_writes.size() != 0) begin
                w = pending_writes.pop_front();
                cfg_index <= w.index;
                cfg_data  <= w.data;
                cfg_valid <= 1'b1;
            end else begin
                cfg_valid <= 1'b0;
            end
        end
    end

    // monitor: track register writes, predict accepted words, check results
    always @(posedge aclk) begin : watch_streams
        vec3_t want;
        vec3_t got;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_ROW_X, REG_ROW_Y, REG_ROW_Z: begin
                        for (int l = 0; l < 3; l++) begin
                            matrix_coef[cfg_index[1:0]][l] = cfg_data[l*COEF_W +: COEF_W];
                        end
                    end
                    REG_OFF_X: offset_lane[0] = cfg_data[COMP_W-1:0];
                    REG_OFF_Y: offset_lane[1] = cfg_data[COMP_W-1:0];
                    REG_OFF_Z: offset_lane[2] = cfg_data[COMP_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                predicted_outputs.push_back(transform_vector(s_tdata, s_tuser));
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (predicted_outputs.size() == 0) begin
                    $error("result word with no prediction pending: %h", m_tdata);
                    error_count++;
                end else begin
                    want = predicted_outputs.pop_front();
                    check_lane("out_x", want.x, got.x);
                    check_lane("out_y", want.y, got.y);
                    check_lane("out_z", want.z, got.z);
                end
            end
        end
    end

    task automatic push_vector(comp_t x, comp_t y, comp_t z, logic add_offset);
        src_word_t w;
        w.v.x = x;
        w.v.y = y;
        w.v.z = z;
        w.add_offset = add_offset;
        pending_vectors.push_back(w);
    endtask

    task automatic push_write(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        reg_write_t w;
        w.index = index;
        w.data  = data;
        pending_writes.push_back(w);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pack_row(coef_t a, coef_t b, coef_t c);
        return {c, b, a};
    endfunction

    // uniform matrix in all nine coefficients, translation with junk above bit 31
    task automatic push_flat_matrix(coef_t c, logic [CFG_DATA_W-1:0] off);
        push_write(REG_ROW_X, pack_row(c, c, c));
        push_write(REG_ROW_Y, pack_row(c, c, c));
        push_write(REG_ROW_Z, pack_row(c, c, c));
        push_write(REG_OFF_X, off);
        push_write(REG_OFF_Y, off);
        push_write(REG_OFF_Z, off);
    endtask

    function automatic coef_t pick_coef();
        case ($urandom_range(5))
            0: return COEF_MIN;
            1: return COEF_MAX;
            2: return coef_t'(int'($urandom_range(2 * int'(UNITY))) - int'(UNITY));
            3: return coef_t'(0);
            default: return coef_t'($urandom);
        endcase
    endfunction

    function automatic comp_t pick_comp();
        case ($urandom_range(7))
            0: return COMP_MIN;
            1: return COMP_MAX;
            2: return comp_t'(int'($urandom_range(2)) - 1);
            3: return comp_t'(int'($urandom_range(20000)) - 10000);
            default: return comp_t'($urandom);
        endcase
    endfunction

    // wait until no word, write or prediction is outstanding
    task automatic wait_drained();
        while (pending_vectors.size() != 0 || s_tvalid || predicted_outputs.size() != 0 ||
               pending_writes.size() != 0 || cfg_valid) begin
            @(negedge aclk);
        end
    endtask

    // stimulus and end of run
    initial begin
        load_reset_matrix();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // identity after reset, extremes pass straight through
        push_vector('0, '0, '0, 1'b0);
        push_vector(COMP_MAX, COMP_MIN, -1, 1'b0);
        push_vector(COMP_MIN, COMP_MAX, 1, 1'b1);
        push_vector(-1, -1, -1, 1'b1);
        wait_drained();

        // writes past the register list, then most negative coefficients
        push_write(REG_SPARE_6, {CFG_DATA_W{1'b1}});
        push_write(REG_SPARE_7, 48'h5a5a_a5a5_5a5a);
        push_flat_matrix(COEF_MIN, {16'hffff, COMP_MAX});
        wait_drained();
        push_vector(COMP_MIN, COMP_MIN, COMP_MIN, 1'b1);
        push_vector(COMP_MAX, COMP_MAX, COMP_MAX, 1'b1);
        push_vector(COMP_MIN, COMP_MAX, '0, 1'b0);
        push_vector(1, -1, 1, 1'b1);
        wait_drained();

        // most positive coefficients, sums wrap past the offset
        push_flat_matrix(COEF_MAX, {16'h5555, COMP_MIN});
        wait_drained();
        push_vector(COMP_MAX, COMP_MAX, COMP_MAX, 1'b1);
        push_vector(COMP_MIN, COMP_MIN, COMP_MIN, 1'b1);
        push_vector(-1, COMP_MAX, COMP_MIN, 1'b0);
        wait_drained();

        // tiny coefficients, negative products truncate toward zero
        push_write(REG_ROW_X, pack_row(16'sh0001, -16'sh0001, 16'sh0001));
        push_write(REG_ROW_Y, pack_row(-16'sh0001, 16'sh0001, -16'sh0001));
        push_write(REG_ROW_Z, pack_row(16'sh0001, 16'sh0001, -16'sh0001));
        push_write(REG_OFF_X, 48'h0000_0000_0007);
        push_write(REG_OFF_Y, 48'hffff_ffff_fff9);
        push_write(REG_OFF_Z, 48'h1234_0000_0000);
        wait_drained();
        push_vector(-1, -1, -1, 1'b0);
        push_vector(4095, -4095, 4097, 1'b1);
        push_vector(-4097, 4096, -4096, 1'b0);
        push_vector(-8191, 8191, -4096, 1'b1);
        wait_drained();

        // random matrices and vectors
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if ($urandom_range(3) == 0) begin
                push_write($urandom_range(1) ? REG_SPARE_6 : REG_SPARE_7,
                           {16'($urandom), 32'($urandom)});
            end
            push_write(REG_ROW_X, pack_row(pick_coef(), pick_coef(), pick_coef()));
            push_write(REG_ROW_Y, pack_row(pick_coef(), pick_coef(), pick_coef()));
            push_write(REG_ROW_Z, pack_row(pick_coef(), pick_coef(), pick_coef()));
            push_write(REG_OFF_X, {16'($urandom), pick_comp()});
            push_write(REG_OFF_Y, {16'($urandom), pick_comp()});
            push_write(REG_OFF_Z, {16'($urandom), pick_comp()});
            wait_drained();
            steady = (p == STEADY_PHASE);
            pressure_armed = (p == PRESSURE_PHASE);
            for (int i = 0; i < PHASE_VECTORS; i++) begin
                push_vector(pick_comp(), pick_comp(), pick_comp(), 1'($urandom));
            end
            wait_drained();
            steady = 1'b0;
            pressure_armed = 1'b0;
        end

        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (error_count == 0) begin
            $display("fixed_point_vector_transform verification clean");
        end else begin
            $display("fixed_point_vector_transform verification failed");
        end
        $finish;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("fixed_point_vector_transform verification failed");
        $finish;
    end

endmodule

// File: filelist.f
sv/fpvt_pkg.sv
sv/fpvt_cfg.sv
sv/fixed_point_vector_transform.sv
test/fixed_point_vector_transform_test.sv
